### src/lcgd_pkg.sv
// ----------------------------------------------------------------------------
// lcgd_pkg
// Constants and types shared by the line descrambler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lcgd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = 32;

  localparam logic [WORD_W-1:0] LCG_MUL    = 32'd22695477;
  localparam logic [WORD_W-1:0] LCG_INC    = 32'd1;
  localparam logic [WORD_W-1:0] SEED_RESET = 32'd272727;
  localparam logic [BYTE_W-1:0] LINE_END   = 8'h0A;
  localparam logic [14:0]       R_MASK     = 15'h7FFF;
  localparam logic [1:0]        K_SCALE    = 2'd3;

  // Seed advanced once, worked out at elaboration for the reset value.
  localparam logic [WORD_W-1:0] SEED_ADV_RESET =
    WORD_W'((64'(SEED_RESET) * 64'(LCG_MUL)) + 64'(LCG_INC));

  // Register map: word index taken from paddr[2].
  localparam logic REG_SEED = 1'b0;

  // Control from the datapath to the generator.
  typedef struct packed {
    logic cfg_we;     // seed write
    logic step;       // advance on a data byte
    logic reload;     // terminator: restart from seed
  } ks_ctrl_t;

  function automatic logic [WORD_W-1:0] lcg_next(input logic [WORD_W-1:0] s);
    lcg_next = (s * LCG_MUL) + LCG_INC;
  endfunction

endpackage

`default_nettype wire

### src/lcgd_keystream.sv
// ----------------------------------------------------------------------------
// lcgd_keystream
// Seed register, reloaded-seed register and generator state.
// ----------------------------------------------------------------------------
`default_nettype none

module lcgd_keystream (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire lcgd_pkg::ks_ctrl_t        ctrl,
  input  wire logic [lcgd_pkg::WORD_W-1:0] cfg_data,
  output logic      [lcgd_pkg::WORD_W-1:0] seed,
  output logic      [lcgd_pkg::WORD_W-1:0] ks_next
);
  import lcgd_pkg::*;

  logic [WORD_W-1:0] seed_adv;
  logic [WORD_W-1:0] cfg_adv;
  logic [WORD_W-1:0] state;

  assign ks_next = lcg_next(state);
  assign cfg_adv = lcg_next(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      seed     <= SEED_RESET;
      seed_adv <= SEED_ADV_RESET;
      state    <= SEED_ADV_RESET;
    end else begin
      if (ctrl.cfg_we) begin
        seed     <= cfg_data;
        seed_adv <= cfg_adv;
      end
      priority if (ctrl.cfg_we) begin
        state <= cfg_adv;
      end else if (ctrl.reload) begin
        state <= seed_adv;
      end else if (ctrl.step) begin
        state <= ks_next;
      end
    end
  end

endmodule

`default_nettype wire

### src/lcg_keystream_line_descrambler.sv
// ----------------------------------------------------------------------------
// lcg_keystream_line_descrambler
// Newline-framed descrambler driven by a 32-bit LCG keystream.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream: one scrambled byte per request in s_tdata[7:0].
//   m_* stream: one result per input; m_tdata[7:0] is the plain byte,
//   m_tlast marks the 0x0A terminator (data 0 then).
//   APB port: register 0 (byte address 0) is the seed. Writing it reloads
//   the generator with seed*22695477+1 at once; write only while idle.
// Path: an accepted byte goes into the input register, then into the
//   output register, from which its result is offered.
// Throughput: one byte per cycle while the output is not stalled. The
//   generator multiply-add on the state register is the loop that sets this.
// Reset: seed returns to 272727, generator to that seed advanced once,
//   both pipeline stages empty.
// Stall: with m_tready low the output register holds; the input register
//   still takes one more byte before s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module lcg_keystream_line_descrambler (
  input  wire logic       clk,
  input  wire logic       rst,
  // stream in
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] raw_byte
  // stream out
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] plain_byte
  output logic            m_tlast,   // end_of_packet
  // APB
  input  wire logic       psel,
  input  wire logic       penable,
  input  wire logic       pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import lcgd_pkg::*;

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              advance;
  logic              move;
  logic              is_term;
  ks_ctrl_t          ctrl;
  logic [WORD_W-1:0] seed;
  logic [WORD_W-1:0] ks_next;
  logic [14:0]       r_val;
  logic [16:0]       r_x3;
  logic [BYTE_W-1:0] k_val;
  logic [BYTE_W-1:0] plain_next;

  assign advance  = !m_tvalid || m_tready;
  assign move     = in_valid && advance;
  assign s_tready = !in_valid || advance;
  assign is_term  = (in_byte == LINE_END);

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SEED) ? seed : '0;

  always_comb begin
    ctrl.cfg_we = psel && penable && pwrite && (paddr[2] == REG_SEED);
    ctrl.step   = move && !is_term;
    ctrl.reload = move && is_term;
  end

  lcgd_keystream u_keystream (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .cfg_data (pwdata),
    .seed     (seed),
    .ks_next  (ks_next)
  );

  // k = 1 + floor(3r / 32768), r = bits 30..16 of the advanced state
  always_comb begin
    r_val      = ks_next[30:16] & R_MASK;
    r_x3       = 17'(r_val) * 17'(K_SCALE);
    k_val      = BYTE_W'(r_x3[16:15]) + 8'd1;
    plain_next = is_term ? '0 : (in_byte - k_val);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        m_tvalid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
    if (move) begin
      m_tdata <= plain_next;
      m_tlast <= is_term;
    end
  end

endmodule

`default_nettype wire

### src/lcgd_checker.sv
// ----------------------------------------------------------------------------
// lcgd_checker
// Port-level checks for the line descrambler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lcgd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast,
  input wire logic       pready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed under stall");

  // terminator carries zero data
  a_term_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == 8'd0)
    else $error("terminator with nonzero data");

  // nothing offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // input side keeps taking bytes while the output drains
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output ready");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind lcg_keystream_line_descrambler lcgd_checker u_lcgd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .pready   (pready)
);

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Bench for the line descrambler. Scrambled bytes go in on the input stream.
// Each result is checked against an in-bench keystream model.
// Directed cases cover byte extremes, terminators, seed writes and the unused
// register. Random packets follow under several seeds, with random gaps on
// both streams and one long output stall.
// ----------------------------------------------------------------------------

module tb;
  import lcgd_pkg::*;

  localparam logic [2:0] ADDR_SEED  = 3'd0;  // register 0
  localparam logic [2:0] ADDR_SPARE = 3'd4;  // register 1, not implemented
  localparam int unsigned SEED_IDX  = 0;
  localparam int unsigned MAX_PRINT = 40;

  typedef struct packed {
    logic [7:0] plain;
    logic       eop;
  } plain_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;      // [7:0] raw_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;              // [7:0] plain_byte
  logic        m_tlast;              // end_of_packet
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // keystream model
  logic [31:0]   seed_reg = SEED_RESET;
  logic [31:0]   ks_state;
  plain_result_t expected_plain_q[$];

  int errors     = 0;
  int bytes_sent = 0;
  bit tx_random  = 1'b0;
  bit rx_random  = 1'b0;
  int rx_hold    = 0;

  lcg_keystream_line_descrambler dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk = ~clk;

  function automatic logic [31:0] lcg_adv(input logic [31:0] s);
    logic [63:0] p;
    p = {32'd0, s} * {32'd0, LCG_MUL} + {32'd0, LCG_INC};
    return p[31:0];
  endfunction

  // Advances the keystream model by one byte, or reloads it from the seed on a terminator, and returns the result.
  function automatic plain_result_t descramble_byte(input logic [7:0] raw);
    plain_result_t res;
    logic [14:0]   r15;
    logic [16:0]   prod;
    logic [7:0]    k;
    if (raw == LINE_END) begin
      ks_state  = lcg_adv(seed_reg);
      res.plain = 8'h00;
      res.eop   = 1'b1;
    end else begin
      ks_state  = lcg_adv(ks_state);
      r15       = ks_state[30:16];
      prod      = {2'b00, r15} * 17'd3;
      k         = {6'd0, prod[16:15]} + 8'd1;
      res.plain = raw - k;
      res.eop   = 1'b0;
    end
    return res;
  endfunction

  // mostly short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] data_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == LINE_END);
    return b;
  endfunction

  // Called at a clock edge; returns at the edge where the request is taken.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = (tx_random && $urandom_range(0, 3) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    expected_plain_q.push_back(descramble_byte(b));
    bytes_sent++;
  endtask

  task automatic send_packet(input int len, input bit noisy);
    for (int i = 0; i < len; i++)
      send_byte(noisy ? 8'($urandom_range(0, 255)) : data_byte());
    send_byte(LINE_END);
  endtask

  task automatic wait_idle();
    int n;
    n = 0;
    s_tvalid <= 1'b0;
    while (expected_plain_q.size() != 0 && n < 5000) begin
      @(posedge clk);
      n++;
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    int unsigned idx;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    idx = 32'(addr) >> 2;
    if (idx == SEED_IDX) begin
      seed_reg = data;
      ks_state = lcg_adv(data);
    end
    @(posedge clk);
  endtask

  task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] exp_val);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== exp_val) begin
      errors++;
      $display("%0t: prdata at %0d expected %08h actual %08h", $time, addr, exp_val, got);
    end
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_bytes();
    logic [7:0] vec [12];
    vec = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h03, 8'h55, 8'hAA, 8'h09, 8'h0B,
            LINE_END, LINE_END, 8'h80};
    foreach (vec[i]) send_byte(vec[i]);
    send_byte(LINE_END);
    wait_idle();
  endtask

  task automatic test_seed_registers();
    apb_read_check(ADDR_SEED, SEED_RESET);
    apb_write(ADDR_SEED, 32'h0000_0000);
    send_byte(8'h00);
    send_byte(8'h10);
    send_byte(LINE_END);
    wait_idle();
    apb_write(ADDR_SEED, 32'hFFFF_FFFF);
    apb_read_check(ADDR_SEED, 32'hFFFF_FFFF);
    send_packet(3, 1'b0);
    wait_idle();
    // unmapped register: write must leave seed and keystream alone
    apb_write(ADDR_SPARE, 32'h1234_5678);
    apb_read_check(ADDR_SEED, 32'hFFFF_FFFF);
    send_packet(2, 1'b0);
    wait_idle();
  endtask

  // seed write in the middle of a packet restarts the keystream there
  task automatic test_mid_packet_seed();
    for (int i = 0; i < 4; i++) send_byte(data_byte());
    wait_idle();
    apb_write(ADDR_SEED, $urandom);
    send_packet(4, 1'b0);
    wait_idle();
  endtask

  // output held off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    tx_random = 1'b0;
    rx_random = 1'b0;
    @(posedge clk);
    rx_hold = 200;
    send_packet(12, 1'b0);
    send_packet(15, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_packets();
    int start;
    int len;
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      apb_write(ADDR_SEED, $urandom);
      tx_random = (ph == 1 || ph >= 3);
      rx_random = (ph >= 2);
      start = bytes_sent;
      while (bytes_sent - start < 120) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 20);
        send_packet(len, $urandom_range(0, 9) == 0);
      end
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------- processes

  initial begin : rx_ready
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (rx_random && $urandom_range(0, 4) == 0) stall_left = gap_len();
      end
    end
  end

  always @(posedge clk) begin : result_check
    plain_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_plain_q.size() == 0) begin
        errors++;
        if (errors <= MAX_PRINT)
          $display("%0t: unexpected result, expected none, actual plain_byte %02h eop %0b",
                   $time, m_tdata, m_tlast);
      end else begin
        exp_r = expected_plain_q.pop_front();
        if (m_tdata !== exp_r.plain) begin
          errors++;
          if (errors <= MAX_PRINT)
            $display("%0t: plain_byte expected %02h actual %02h", $time, exp_r.plain, m_tdata);
        end
        if (m_tlast !== exp_r.eop) begin
          errors++;
          if (errors <= MAX_PRINT)
            $display("%0t: end_of_packet expected %0b actual %0b", $time, exp_r.eop, m_tlast);
        end
      end
    end
  end

  initial begin
    ks_state = lcg_adv(SEED_RESET);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_bytes();
    test_seed_registers();
    test_mid_packet_seed();
    test_backpressure();
    test_random_packets();
    wait_idle();
    if (expected_plain_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results expected, actual none", $time, expected_plain_q.size());
    end
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2ms;
    $display("tb failed");
    $finish;
  end

endmodule
